@@ rtl/pfcba_pkg.sv @@
// Shared types, constants and helpers for the PFC ingress buffer accounting block.
package pfcba_pkg;

    localparam int CNT_W   = 25;
    localparam int RES_W   = 20;
    localparam int PKT_W   = 14;
    localparam int PORT_W  = 4;
    localparam int QUEUE_W = 3;
    localparam int CFG_W   = 25;

    localparam int NUM_PORTS_DEF  = 16;
    localparam int NUM_QUEUES_DEF = 8;

    localparam logic [RES_W-1:0] RESERVE_RST    = RES_W'(4 * 1024);
    localparam logic [RES_W-1:0] RESUME_OFS_RST = RES_W'(3 * 1024);

    typedef enum logic {
        FUNC_ARRIVAL   = 1'b0,
        FUNC_DEPARTURE = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        REG_RESERVE      = 2'd0,
        REG_RESUME_OFS   = 2'd1,
        REG_SHARED_LIM   = 2'd2,
        REG_HEADROOM_LIM = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        func_t                func;
        logic [PORT_W-1:0]    port_index;
        logic [QUEUE_W-1:0]   queue_index;
        logic [PKT_W-1:0]     packet_bytes;
    } evt_t;

    typedef struct packed {
        logic                 dropped;
        logic                 send_pause;
        logic                 send_resume;
        logic [PORT_W-1:0]    event_port;
        logic [QUEUE_W-1:0]   event_queue;
        logic [CNT_W-1:0]     shared_total;
    } res_t;

    typedef struct packed {
        logic [RES_W-1:0]     reserve_bytes;
        logic [RES_W-1:0]     resume_offset_bytes;
        logic [CNT_W-1:0]     shared_limit;
        logic [CNT_W-1:0]     headroom_limit;
    } cfg_t;

    // one per-queue entry of the state memory
    typedef struct packed {
        logic [CNT_W-1:0]     ingress;
        logic [CNT_W-1:0]     headroom;
        logic                 paused;
    } qstate_t;

    localparam int ENTRY_W = $bits(qstate_t);

    typedef struct packed {
        logic                 s1_en;
        logic                 s2_en;
        logic                 s3_en;
        logic                 in_range;
    } upd_ctl_t;

    typedef struct packed {
        qstate_t              qnext;
        logic                 wr;
        logic                 dropped;
        logic                 send_pause;
        logic                 send_resume;
        logic [CNT_W-1:0]     shared_total;
    } upd_res_t;

    // saturate a one-bit-grown sum to the counter width
    function automatic logic [CNT_W-1:0] sat_cnt(input logic [CNT_W:0] v);
        return v[CNT_W] ? {CNT_W{1'b1}} : v[CNT_W-1:0];
    endfunction

endpackage

@@ rtl/pfcba_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pfcba_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/pfcba_cfg.sv @@
// Configuration register file: reserve, resume offset, shared and headroom limits.
module pfcba_cfg (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     we,
    input  pfcba_pkg::cfg_idx_t      index,
    input  logic [pfcba_pkg::CFG_W-1:0] data,
    output pfcba_pkg::cfg_t          cfg
);
    import pfcba_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (we)
        begin
            unique case (index)
                REG_RESERVE:      cfg_next.reserve_bytes       = data[RES_W-1:0];
                REG_RESUME_OFS:   cfg_next.resume_offset_bytes = data[RES_W-1:0];
                REG_SHARED_LIM:   cfg_next.shared_limit        = data[CNT_W-1:0];
                REG_HEADROOM_LIM: cfg_next.headroom_limit      = data[CNT_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reserve_bytes       <= RESERVE_RST;
            cfg_reg.resume_offset_bytes <= RESUME_OFS_RST;
            cfg_reg.shared_limit        <= '0;
            cfg_reg.headroom_limit      <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/pfcba_update.sv @@
// Three-stage read-modify datapath computing a queue's new state and the event flags.
module pfcba_update (
    input  logic                        clk,
    input  pfcba_pkg::cfg_t             cfg,
    input  pfcba_pkg::evt_t             evt,
    input  pfcba_pkg::qstate_t          qcur,
    input  pfcba_pkg::upd_ctl_t         ctl,
    input  logic [pfcba_pkg::CNT_W-1:0] shared_cur,
    output pfcba_pkg::upd_res_t         res
);
    import pfcba_pkg::*;

    localparam int W1 = CNT_W + 1;

    logic              arrival;
    logic [W1-1:0]     p_w1;
    logic [CNT_W-1:0]  p_cnt;
    logic [CNT_W-1:0]  res_cnt;
    logic [W1-1:0]     thr_w1;

    assign arrival = (evt.func == FUNC_ARRIVAL);
    assign p_w1    = W1'(evt.packet_bytes);
    assign p_cnt   = CNT_W'(evt.packet_bytes);
    assign res_cnt = CNT_W'(cfg.reserve_bytes);
    assign thr_w1  = W1'(cfg.shared_limit);

    // ---- stage 1: sums and differences off the memory word
    logic [W1-1:0]     hsum;
    logic              s1_drop_c;
    logic [W1-1:0]     s1_nb_c;
    logic [W1-1:0]     s1_nbr_c;
    logic [CNT_W-1:0]  s1_over_c;
    logic [PKT_W-1:0]  s1_from_h_c;
    logic [CNT_W-1:0]  s1_ing_sub_c;

    always_comb
    begin
        hsum         = W1'(qcur.headroom) + p_w1;
        s1_drop_c    = hsum > W1'(cfg.headroom_limit);
        s1_nb_c      = W1'(qcur.ingress) + p_w1;
        s1_nbr_c     = s1_nb_c - W1'(cfg.reserve_bytes);
        s1_over_c    = (qcur.ingress > res_cnt) ? (qcur.ingress - res_cnt) : '0;
        s1_from_h_c  = (qcur.headroom < p_cnt) ? PKT_W'(qcur.headroom) : evt.packet_bytes;
        s1_ing_sub_c = (qcur.ingress > p_cnt) ? (qcur.ingress - p_cnt) : '0;
    end

    logic [CNT_W-1:0]  s1_hdrm_reg;
    logic              s1_paused_reg;
    logic              s1_drop_reg;
    logic [W1-1:0]     s1_nb_reg;
    logic              s1_nbpos_reg;
    logic [W1-1:0]     s1_nbr_reg;
    logic [CNT_W-1:0]  s1_over_reg;
    logic [PKT_W-1:0]  s1_from_h_reg;
    logic [CNT_W-1:0]  s1_ing_sub_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.s1_en)
        begin
            s1_hdrm_reg    <= qcur.headroom;
            s1_paused_reg  <= qcur.paused;
            s1_drop_reg    <= s1_drop_c;
            s1_nb_reg      <= s1_nb_c;
            s1_nbpos_reg   <= s1_nb_c > W1'(cfg.reserve_bytes);
            s1_nbr_reg     <= s1_nbr_c;
            s1_over_reg    <= s1_over_c;
            s1_from_h_reg  <= s1_from_h_c;
            s1_ing_sub_reg <= s1_ing_sub_c;
        end
    end

    // ---- stage 2: shared charge, departure split, new ingress count
    logic              s2_spill_c;
    logic [CNT_W-1:0]  s2_inc_c;
    logic [PKT_W-1:0]  rem;
    logic [PKT_W-1:0]  s2_from_s_c;

    always_comb
    begin
        s2_spill_c = s1_nbpos_reg && (s1_nbr_reg > thr_w1);
        if (!s1_nbpos_reg)
        begin
            s2_inc_c = '0;
        end
        else if (s2_spill_c)
        begin
            // straddling packet: fill shared up to the threshold only
            s2_inc_c = (s1_over_reg >= cfg.shared_limit) ? '0
                                                         : (cfg.shared_limit - s1_over_reg);
        end
        else
        begin
            s2_inc_c = (s1_nbr_reg < p_w1) ? s1_nbr_reg[CNT_W-1:0] : p_cnt;
        end
        rem         = evt.packet_bytes - s1_from_h_reg;
        s2_from_s_c = (CNT_W'(rem) < s1_over_reg) ? rem : PKT_W'(s1_over_reg);
    end

    logic [CNT_W-1:0]  s2_inc_reg;
    logic              s2_spill_reg;
    logic [PKT_W-1:0]  s2_from_s_reg;
    logic [CNT_W-1:0]  s2_ing_new_reg;
    logic [CNT_W-1:0]  s2_hdrm_reg;
    logic [CNT_W-1:0]  s2_hdrm_dep_reg;
    logic              s2_paused_reg;
    logic              s2_drop_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.s2_en)
        begin
            s2_inc_reg      <= s2_inc_c;
            s2_spill_reg    <= s2_spill_c;
            s2_from_s_reg   <= s2_from_s_c;
            s2_ing_new_reg  <= arrival ? sat_cnt(s1_nb_reg) : s1_ing_sub_reg;
            s2_hdrm_reg     <= s1_hdrm_reg;
            s2_hdrm_dep_reg <= s1_hdrm_reg - CNT_W'(s1_from_h_reg);
            s2_paused_reg   <= s1_paused_reg;
            s2_drop_reg     <= s1_drop_reg;
        end
    end

    // ---- stage 3: shared total, headroom excess, shared use of the queue
    logic [PKT_W-1:0]  s3_excess_c;
    logic [CNT_W-1:0]  s3_shared_c;
    logic [CNT_W-1:0]  ing_over;
    logic [CNT_W-1:0]  s3_su_c;
    logic [CNT_W-1:0]  from_s_cnt;

    always_comb
    begin
        from_s_cnt  = CNT_W'(s2_from_s_reg);
        s3_excess_c = (p_cnt > s2_inc_reg) ? PKT_W'(p_cnt - s2_inc_reg) : '0;
        if (arrival)
        begin
            s3_shared_c = sat_cnt(W1'(shared_cur) + W1'(s2_inc_reg));
        end
        else
        begin
            s3_shared_c = (shared_cur > from_s_cnt) ? (shared_cur - from_s_cnt) : '0;
        end
        ing_over = s2_ing_new_reg - res_cnt;
        if (s2_ing_new_reg > res_cnt)
        begin
            s3_su_c = (ing_over < cfg.shared_limit) ? ing_over : cfg.shared_limit;
        end
        else
        begin
            s3_su_c = '0;
        end
    end

    logic [PKT_W-1:0]  s3_excess_reg;
    logic [CNT_W-1:0]  s3_shared_reg;
    logic [CNT_W-1:0]  s3_su_reg;
    logic [CNT_W-1:0]  s3_ing_new_reg;
    logic [CNT_W-1:0]  s3_hdrm_reg;
    logic [CNT_W-1:0]  s3_hdrm_dep_reg;
    logic              s3_spill_reg;
    logic              s3_paused_reg;
    logic              s3_drop_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.s3_en)
        begin
            s3_excess_reg   <= s3_excess_c;
            s3_shared_reg   <= s3_shared_c;
            s3_su_reg       <= s3_su_c;
            s3_ing_new_reg  <= s2_ing_new_reg;
            s3_hdrm_reg     <= s2_hdrm_reg;
            s3_hdrm_dep_reg <= s2_hdrm_dep_reg;
            s3_spill_reg    <= s2_spill_reg;
            s3_paused_reg   <= s2_paused_reg;
            s3_drop_reg     <= s2_drop_reg;
        end
    end

    // ---- final: pause / resume decision and the word to write back
    logic [CNT_W-1:0]  hdrm_arr;
    logic              pause;
    logic              resume;
    logic              admit;

    always_comb
    begin
        hdrm_arr = s3_spill_reg ? sat_cnt(W1'(s3_hdrm_reg) + W1'(s3_excess_reg))
                                : s3_hdrm_reg;
        pause    = !s3_paused_reg && ((hdrm_arr != '0) || (s3_su_reg >= cfg.shared_limit));
        resume   = s3_paused_reg && (s3_hdrm_dep_reg == '0) &&
                   ((s3_su_reg == '0) ||
                    ((W1'(s3_su_reg) + W1'(cfg.resume_offset_bytes)) <= thr_w1));
        admit    = ctl.in_range && !(arrival && s3_drop_reg);

        res.wr           = admit;
        res.dropped      = ctl.in_range && arrival && s3_drop_reg;
        res.send_pause   = admit && arrival && pause;
        res.send_resume  = admit && !arrival && resume;
        res.shared_total = admit ? s3_shared_reg : shared_cur;
        res.qnext.ingress  = s3_ing_new_reg;
        res.qnext.headroom = arrival ? hdrm_arr : s3_hdrm_dep_reg;
        res.qnext.paused   = arrival ? (s3_paused_reg || pause) : (s3_paused_reg && !resume);
    end

endmodule

@@ rtl/pfc_ingress_buffer_accounting.sv @@
// Top level of the PFC ingress buffer accounting block.
//
// Usage:
//   evt channel (valid/ready) carries one packet transaction: arrival or
//   departure, port, priority queue and size. res channel (valid/ready)
//   returns exactly one result per transaction: drop flag, pause / resume
//   edges for that queue and the shared byte total after the event.
//   cfg_we/cfg_index/cfg_data write the four limit registers; write only
//   while no transaction is in flight.
// Timing:
//   Per-queue counters sit in a one-port-read, one-port-write RAM. A
//   transaction walks RAM read, three compute stages and a write-back, and
//   res_valid rises with the write-back; no new transaction is taken until
//   the write-back is done. One transaction is in the read-modify-write
//   loop at a time, which also keeps reads and writes of one entry apart.
// Reset:
//   Asynchronous, active low. Queue entries are marked invalid by a valid
//   bit per entry and read as zero until first written, so no clear sweep
//   runs; the block takes transactions right after reset.
// Stall:
//   The result sits in an output register. A new transaction is accepted
//   while it waits; the next write-back holds until the result is taken.
module pfc_ingress_buffer_accounting #(
    parameter int NUM_PORTS  = pfcba_pkg::NUM_PORTS_DEF,
    parameter int NUM_QUEUES = pfcba_pkg::NUM_QUEUES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        evt_valid,
    output logic                        evt_ready,
    input  pfcba_pkg::evt_t             evt,
    output logic                        res_valid,
    input  logic                        res_ready,
    output pfcba_pkg::res_t             res,
    input  logic                        cfg_we,
    input  pfcba_pkg::cfg_idx_t         cfg_index,
    input  logic [pfcba_pkg::CFG_W-1:0] cfg_data
);
    import pfcba_pkg::*;

    // only ports reachable through the port field get storage
    localparam int PORTS_EFF = (NUM_PORTS < (2 ** PORT_W)) ? NUM_PORTS : (2 ** PORT_W);
    localparam int DEPTH     = PORTS_EFF * NUM_QUEUES;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW        = AW + PORT_W + QUEUE_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_S1,
        ST_S2,
        ST_S3,
        ST_DONE
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic              res_valid_reg;
    logic              res_valid_next;
    res_t              res_reg;
    res_t              res_next;

    evt_t              evt_reg;
    logic [AW-1:0]     addr_reg;
    logic              in_range_reg;
    logic [DEPTH-1:0]  vld_reg;
    logic [DEPTH-1:0]  vld_next;
    logic [CNT_W-1:0]  shared_reg;
    logic [CNT_W-1:0]  shared_next;

    cfg_t              cfg;
    upd_ctl_t          ctl;
    upd_res_t          upd;
    qstate_t           qcur;
    logic [ENTRY_W-1:0] ram_rdata;

    logic              evt_acc;
    logic              commit;
    logic [FW-1:0]     addr_full;
    logic              in_range;

    // transaction taken only when the RMW loop is free
    assign evt_ready = (state_reg == ST_IDLE);
    assign evt_acc   = evt_valid && evt_ready;
    // write-back waits for the output register to be free
    assign commit    = (state_reg == ST_DONE) && (!res_valid_reg || res_ready);

    assign addr_full = FW'(evt.port_index) * FW'(NUM_QUEUES) + FW'(evt.queue_index);
    assign in_range  = (32'(evt.port_index) < 32'(NUM_PORTS)) &&
                       (32'(evt.queue_index) < 32'(NUM_QUEUES));

    pfcba_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    pfcba_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_qram (
        .clk   (clk),
        .we    (commit && upd.wr),
        .waddr (addr_reg),
        .wdata (upd.qnext),
        .re    (evt_acc),
        .raddr (addr_full[AW-1:0]),
        .rdata (ram_rdata)
    );

    // never-written entries read as the reset state
    assign qcur = vld_reg[addr_reg] ? qstate_t'(ram_rdata) : '0;

    assign ctl.s1_en    = (state_reg == ST_S1);
    assign ctl.s2_en    = (state_reg == ST_S2);
    assign ctl.s3_en    = (state_reg == ST_S3);
    assign ctl.in_range = in_range_reg;

    pfcba_update u_upd (
        .clk        (clk),
        .cfg        (cfg),
        .evt        (evt_reg),
        .qcur       (qcur),
        .ctl        (ctl),
        .shared_cur (shared_reg),
        .res        (upd)
    );

    // captured transaction fields
    always_ff @(posedge clk)
    begin
        if (evt_acc)
        begin
            evt_reg      <= evt;
            addr_reg     <= addr_full[AW-1:0];
            in_range_reg <= in_range;
        end
    end

    always_comb
    begin
        vld_next    = vld_reg;
        shared_next = shared_reg;
        if (commit)
        begin
            shared_next = upd.shared_total;
            if (upd.wr)
            begin
                vld_next[addr_reg] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            shared_reg <= '0;
        end
        else
        begin
            vld_reg    <= vld_next;
            shared_reg <= shared_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_next       = res_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (evt_acc)
                begin
                    state_next = ST_S1;
                end
            end
            ST_S1:   state_next = ST_S2;
            ST_S2:   state_next = ST_S3;
            ST_S3:   state_next = ST_DONE;
            ST_DONE:
            begin
                if (commit)
                begin
                    state_next           = ST_IDLE;
                    res_valid_next       = 1'b1;
                    res_next.dropped     = upd.dropped;
                    res_next.send_pause  = upd.send_pause;
                    res_next.send_resume = upd.send_resume;
                    res_next.event_port  = evt_reg.port_index;
                    res_next.event_queue = evt_reg.queue_index;
                    res_next.shared_total = upd.shared_total;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

@@ rtl/pfcba_checker.sv @@
// Port-level assertions for the PFC ingress buffer accounting block, with bind.
module pfcba_sva (
    input logic             clk,
    input logic             rst_n,
    input logic             evt_valid,
    input logic             evt_ready,
    input logic             res_valid,
    input logic             res_ready,
    input pfcba_pkg::res_t  res
);
    import pfcba_pkg::*;

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    // a dropped arrival never signals pause or resume
    a_drop_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.dropped |-> !res.send_pause && !res.send_resume)
        else $error("dropped transaction with pause or resume");

    // pause and resume are exclusive
    a_pause_resume: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res.send_pause && res.send_resume))
        else $error("pause and resume together");

    // one transaction in the RMW loop at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_ready |=> !evt_ready)
        else $error("transaction accepted while busy");

endmodule

bind pfc_ingress_buffer_accounting pfcba_sva u_pfcba_sva (.*);

@@ tb/pfcba_checker.sv @@
`timescale 1ns / 1ps
// Checker for the PFC ingress accounting block: predicts each result and scores the result channel.
module pfcba_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        evt_valid,
    input  logic                        evt_ready,
    input  pfcba_pkg::evt_t             evt,
    input  logic                        res_valid,
    input  logic                        res_ready,
    input  pfcba_pkg::res_t             res,
    input  logic                        cfg_we,
    input  pfcba_pkg::cfg_idx_t         cfg_index,
    input  logic [pfcba_pkg::CFG_W-1:0] cfg_data,
    output int                          outstanding,
    output int                          errors
);
    import pfcba_pkg::*;

    localparam int NQ_ALL = NUM_PORTS_DEF * NUM_QUEUES_DEF;
    localparam int WIDE_W = CNT_W + 2;

    typedef logic [WIDE_W-1:0] wide_t;

    localparam wide_t CNT_MAX = wide_t'({CNT_W{1'b1}});

    logic [CNT_W-1:0] q_ingress  [NQ_ALL];
    logic [CNT_W-1:0] q_headroom [NQ_ALL];
    logic             q_paused   [NQ_ALL];
    wide_t            shared_sum;

    wide_t            rsv;
    wide_t            resume_ofs;
    wide_t            shr_lim;
    wide_t            hdrm_lim;

    res_t             awaited_results [$];
    res_t             want;
    int               reported;

    function automatic wide_t clip_cnt(input wide_t v);
        return (v > CNT_MAX) ? CNT_MAX : v;
    endfunction

    function automatic wide_t minus0(input wide_t a, input wide_t b);
        return (a > b) ? a - b : '0;
    endfunction

    function automatic wide_t lesser(input wide_t a, input wide_t b);
        return (a < b) ? a : b;
    endfunction

    // shared bytes a queue holds: above the reserve, capped at the threshold
    function automatic wide_t shared_use(input wide_t ing);
        return (ing > rsv) ? lesser(ing - rsv, shr_lim) : '0;
    endfunction

    // applies one packet transaction to the shadow counters, returns its result
    function automatic res_t account_event(input evt_t e);
        res_t  r;
        int    idx;
        wide_t ing;
        wide_t hdrm;
        wide_t psz;
        wide_t nb;
        wide_t over;
        wide_t inc;
        wide_t su;
        wide_t from_h;
        wide_t from_s;

        r    = '0;
        idx  = int'(e.port_index) * NUM_QUEUES_DEF + int'(e.queue_index);
        ing  = wide_t'(q_ingress[idx]);
        hdrm = wide_t'(q_headroom[idx]);
        psz  = wide_t'(e.packet_bytes);

        if (e.func == FUNC_ARRIVAL)
        begin
            if (psz + hdrm > hdrm_lim)
                r.dropped = 1'b1;
            else
            begin
                nb = ing + psz;
                if (nb > rsv)
                begin
                    if (nb - rsv > shr_lim)
                    begin
                        // fill shared up to threshold, spill the rest to headroom
                        over       = minus0(ing, rsv);
                        inc        = (over >= shr_lim) ? '0 : shr_lim - over;
                        shared_sum = clip_cnt(shared_sum + inc);
                        hdrm       = clip_cnt(hdrm + minus0(psz, inc));
                    end
                    else
                        shared_sum = clip_cnt(shared_sum + lesser(psz, nb - rsv));
                end
                ing              = clip_cnt(nb);
                q_ingress[idx]   = ing[CNT_W-1:0];
                q_headroom[idx]  = hdrm[CNT_W-1:0];
                su               = shared_use(ing);
                if (!q_paused[idx] && (hdrm != 0 || su >= shr_lim))
                begin
                    q_paused[idx] = 1'b1;
                    r.send_pause  = 1'b1;
                end
            end
        end
        else
        begin
            // release headroom first, then shared
            from_h          = lesser(hdrm, psz);
            from_s          = lesser(psz - from_h, minus0(ing, rsv));
            hdrm            = hdrm - from_h;
            ing             = minus0(ing, psz);
            shared_sum      = minus0(shared_sum, from_s);
            q_ingress[idx]  = ing[CNT_W-1:0];
            q_headroom[idx] = hdrm[CNT_W-1:0];
            if (q_paused[idx])
            begin
                su = shared_use(ing);
                if (hdrm == 0 && (su == 0 || su + resume_ofs <= shr_lim))
                begin
                    q_paused[idx] = 1'b0;
                    r.send_resume = 1'b1;
                end
            end
        end

        r.event_port   = e.port_index;
        r.event_queue  = e.queue_index;
        r.shared_total = shared_sum[CNT_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NQ_ALL; i++)
            begin
                q_ingress[i]  = '0;
                q_headroom[i] = '0;
                q_paused[i]   = 1'b0;
            end
            shared_sum  = '0;
            rsv         = wide_t'(RESERVE_RST);
            resume_ofs  = wide_t'(RESUME_OFS_RST);
            shr_lim     = '0;
            hdrm_lim    = '0;
            awaited_results.delete();
            outstanding = 0;
            errors      = 0;
            reported    = 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    errors++;
                    if (reported < 10)
                    begin
                        reported++;
                        $display("[%0t] result with nothing awaited: %h", $realtime, res);
                    end
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (res.dropped !== want.dropped || res.send_pause !== want.send_pause ||
                        res.send_resume !== want.send_resume ||
                        res.event_port !== want.event_port ||
                        res.event_queue !== want.event_queue ||
                        res.shared_total !== want.shared_total)
                    begin
                        errors++;
                        if (reported < 10)
                        begin
                            reported++;
                            $display("[%0t] exp drop %b pause %b resume %b port %0d q %0d shared %0d",
                                     $realtime, want.dropped, want.send_pause, want.send_resume,
                                     want.event_port, want.event_queue, want.shared_total);
                            $display("[%0t] got drop %b pause %b resume %b port %0d q %0d shared %0d",
                                     $realtime, res.dropped, res.send_pause, res.send_resume,
                                     res.event_port, res.event_queue, res.shared_total);
                        end
                    end
                end
            end

            if (evt_valid && evt_ready)
                awaited_results.push_back(account_event(evt));

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RESERVE:      rsv        = wide_t'(cfg_data[RES_W-1:0]);
                    REG_RESUME_OFS:   resume_ofs = wide_t'(cfg_data[RES_W-1:0]);
                    REG_SHARED_LIM:   shr_lim    = wide_t'(cfg_data[CNT_W-1:0]);
                    REG_HEADROOM_LIM: hdrm_lim   = wide_t'(cfg_data[CNT_W-1:0]);
                endcase
            end

            outstanding = awaited_results.size();
        end
    end

endmodule

@@ tb/tb_pfc_ingress_buffer_accounting.sv @@
`timescale 1ns / 1ps
// Testbench top for the PFC ingress buffer accounting block: stimulus, watchdog and verdict.
module tb_pfc_ingress_buffer_accounting;
    import pfcba_pkg::*;

    // No accepted transaction on either channel for this many cycles ends the run.
    // Normal gaps are random idle cycles plus the read-modify-write loop and the
    // config settle time, far below this.
    localparam int STALL_LIMIT  = 2000;
    // Extra cycles after the last result.
    localparam int DRAIN_CYCLES = 12;
    localparam int SETTLE_CYCLES = 8;
    localparam int ITEMS_PER_PHASE = 110;
    localparam int FILL_ITEMS = 90;
    localparam logic [CFG_W-1:0] ALL_ONES = {CFG_W{1'b1}};
    localparam logic [PKT_W-1:0] PKT_MAX = {PKT_W{1'b1}};

    logic              clk;
    logic              rst_n;
    logic              evt_valid;
    logic              evt_ready;
    evt_t              evt;
    logic              res_valid;
    logic              res_ready;
    res_t              res;
    logic              cfg_we;
    cfg_idx_t          cfg_index;
    logic [CFG_W-1:0]  cfg_data;

    int                outstanding;
    int                errors;
    int                stall_cycles = 0;
    bit                quiet;        // no idling on either side while set
    int                size_cap;     // upper bound of the "typical" packet size
    logic [PORT_W-1:0]  hot_port  [4];
    logic [QUEUE_W-1:0] hot_queue [4];

    pfc_ingress_buffer_accounting dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt       (evt),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pfcba_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .evt_valid   (evt_valid),
        .evt_ready   (evt_ready),
        .evt         (evt),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .outstanding (outstanding),
        .errors      (errors)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Result side back-pressure: ready drops in about a quarter of cycles.
    always @(negedge clk)
        res_ready <= quiet || ($urandom_range(0, 99) >= 24);

    // Watchdog on accepted transactions of either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (evt_valid && evt_ready) || (res_valid && res_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic evt_t pkt_event(input func_t f, input int p, input int q, input int b);
        evt_t e;
        e.func         = f;
        e.port_index   = PORT_W'(p);
        e.queue_index  = QUEUE_W'(q);
        e.packet_bytes = PKT_W'(b);
        return e;
    endfunction

    // Mostly traffic on a few hot queues so counters build up; the rest is
    // scattered over all ports and queues.
    function automatic evt_t random_event();
        evt_t e;
        int   k;
        int   pick;
        e.func = ($urandom_range(0, 99) < 55) ? FUNC_ARRIVAL : FUNC_DEPARTURE;
        if ($urandom_range(0, 99) < 70)
        begin
            k             = $urandom_range(0, 3);
            e.port_index  = hot_port[k];
            e.queue_index = hot_queue[k];
        end
        else
        begin
            e.port_index  = PORT_W'($urandom);
            e.queue_index = QUEUE_W'($urandom);
        end
        pick = $urandom_range(0, 99);
        if (pick < 8)
            e.packet_bytes = '0;
        else if (pick < 16)
            e.packet_bytes = PKT_MAX;
        else if (pick < 40)
            e.packet_bytes = PKT_W'($urandom);
        else
            e.packet_bytes = PKT_W'($urandom_range(0, size_cap));
        return e;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so the next call decides whether it drops.
    task automatic send_evt(input evt_t e);
        while (!quiet && $urandom_range(0, 99) < 24)
        begin
            evt_valid <= 1'b0;
            @(negedge clk);
        end
        evt_valid <= 1'b1;
        evt       <= e;
        do
            @(posedge clk);
        while (!evt_ready);
        @(negedge clk);
    endtask

    // Stop sending and wait until every awaited result has been taken.
    task automatic drain();
        evt_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // Write all four limit registers once the block is idle.
    task automatic load_config(input logic [CFG_W-1:0] rsv_v, input logic [CFG_W-1:0] ofs_v,
                               input logic [CFG_W-1:0] shr_v, input logic [CFG_W-1:0] hdr_v);
        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_RESERVE;
        cfg_data  <= rsv_v;
        @(negedge clk);
        cfg_index <= REG_RESUME_OFS;
        cfg_data  <= ofs_v;
        @(negedge clk);
        cfg_index <= REG_SHARED_LIM;
        cfg_data  <= shr_v;
        @(negedge clk);
        cfg_index <= REG_HEADROOM_LIM;
        cfg_data  <= hdr_v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    task automatic pick_hot();
        for (int i = 0; i < 4; i++)
        begin
            hot_port[i]  = PORT_W'($urandom);
            hot_queue[i] = QUEUE_W'($urandom);
        end
    endtask

    // One random phase; a pause for all results halfway when asked.
    task automatic run_random(input int n, input bit hold_mid);
        pick_hot();
        for (int i = 0; i < n; i++)
        begin
            if (hold_mid && i == n / 2)
                drain();
            send_evt(random_event());
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        evt_valid = 1'b0;
        evt       = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_RESERVE;
        cfg_data  = '0;
        quiet     = 1'b0;
        size_cap  = 16383;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset limits: zero threshold pauses any admitted arrival, zero size only
        send_evt(pkt_event(FUNC_ARRIVAL, 0, 0, 0));
        send_evt(pkt_event(FUNC_DEPARTURE, 0, 0, 0));
        send_evt(pkt_event(FUNC_ARRIVAL, 15, 7, 16383));

        // small limits: reserve 100, offset 50, threshold 200, headroom 500
        load_config(100, 50, 200, 500);
        send_evt(pkt_event(FUNC_ARRIVAL, 0, 0, 0));
        send_evt(pkt_event(FUNC_ARRIVAL, 15, 7, 100));      // fills reserve exactly
        send_evt(pkt_event(FUNC_ARRIVAL, 15, 7, 150));      // all into shared
        send_evt(pkt_event(FUNC_ARRIVAL, 15, 7, 100));      // crosses threshold, spills
        send_evt(pkt_event(FUNC_ARRIVAL, 15, 7, 500));      // would overflow headroom, dropped
        send_evt(pkt_event(FUNC_ARRIVAL, 15, 7, 450));      // headroom exactly at limit
        send_evt(pkt_event(FUNC_DEPARTURE, 15, 7, 400));    // headroom only
        send_evt(pkt_event(FUNC_DEPARTURE, 15, 7, 300));    // headroom then shared, resume
        send_evt(pkt_event(FUNC_DEPARTURE, 15, 7, 16383));  // underflow clamps at zero
        send_evt(pkt_event(FUNC_DEPARTURE, 8, 3, 16383));   // departure on empty queue
        send_evt(pkt_event(FUNC_ARRIVAL, 0, 0, 16383));     // oversize, dropped
        send_evt(pkt_event(FUNC_ARRIVAL, 1, 2, 50));        // below reserve
        send_evt(pkt_event(FUNC_ARRIVAL, 1, 2, 300));       // straddles reserve and threshold
        send_evt(pkt_event(FUNC_DEPARTURE, 1, 2, 100));     // resume inside hysteresis
        send_evt(pkt_event(FUNC_ARRIVAL, 1, 2, 0));

        // zero reserve and threshold, open headroom
        load_config(0, 0, 0, ALL_ONES);
        send_evt(pkt_event(FUNC_ARRIVAL, 2, 5, 16383));
        send_evt(pkt_event(FUNC_DEPARTURE, 2, 5, 16383));
        send_evt(pkt_event(FUNC_ARRIVAL, 3, 1, 0));
        send_evt(pkt_event(FUNC_DEPARTURE, 3, 1, 0));

        // random phases over several settings
        size_cap = 6000;
        load_config(4096, 3072, 20000, 40000);
        run_random(ITEMS_PER_PHASE, 1'b1);

        // all limits zero, no idling anywhere
        quiet    = 1'b1;
        size_cap = 3;
        load_config(0, 0, 0, 0);
        run_random(ITEMS_PER_PHASE, 1'b0);
        quiet    = 1'b0;

        // all ones, upper bits of the 20-bit registers included
        size_cap = 16383;
        load_config(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
        run_random(ITEMS_PER_PHASE, 1'b0);

        // random limits, junk above bit 19 on the narrow registers
        size_cap = 8000;
        load_config({5'($urandom), 20'($urandom_range(0, 30000))},
                    {5'($urandom), 20'($urandom_range(0, 30000))},
                    CFG_W'($urandom_range(0, 80000)), CFG_W'($urandom_range(0, 80000)));
        run_random(ITEMS_PER_PHASE, 1'b1);

        size_cap = 3000;
        load_config(CFG_W'($urandom_range(0, 2000)), CFG_W'($urandom_range(0, 5000)),
                    CFG_W'($urandom_range(0, 5000)), CFG_W'($urandom_range(0, 20000)));
        run_random(ITEMS_PER_PHASE, 1'b0);

        // Pile maximum packets back to back into one queue to drive its
        // ingress count and the shared total high, then mix in some traffic.
        quiet = 1'b1;
        load_config(0, ALL_ONES, ALL_ONES, ALL_ONES);
        for (int i = 0; i < FILL_ITEMS; i++)
            send_evt(pkt_event(FUNC_ARRIVAL, 9, 6, 16383));
        quiet = 1'b0;
        pick_hot();
        hot_port[0]  = 9;
        hot_queue[0] = 6;
        for (int i = 0; i < 40; i++)
            send_evt(random_event());

        drain();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (errors == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
